// ----- rtl/kas_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package kas_pkg;

  // Timing limits in milliseconds
  localparam int LEAD_LIMIT_MS = 200;
  localparam int PAUSE_GAP_MS  = 900;

  // Back-lerp value for 1.0 in Q1.16
  localparam logic [16:0] FRAC_ONE = 17'h10000;

  // Iterative divider geometry
  localparam int DIVIDEND_W = 49;
  localparam int DIVISOR_W  = 33;
  localparam int STEP_W     = 6;

  // Configuration register indexes
  localparam logic [2:0] CFG_FIRST_FRAME  = 3'd0;
  localparam logic [2:0] CFG_FRAME_COUNT  = 3'd1;
  localparam logic [2:0] CFG_LOOP_LENGTH  = 3'd2;
  localparam logic [2:0] CFG_FRAME_PERIOD = 3'd3;
  localparam logic [2:0] CFG_REVERSE      = 3'd4;
  localparam logic [2:0] CFG_FLIP_FLOP    = 3'd5;
  localparam logic [2:0] CFG_ANIM_ENABLE  = 3'd6;
  localparam logic [2:0] CFG_START_TIME   = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WAIT_F,
    ST_POSTF,
    ST_WAIT_L,
    ST_LOOPF,
    ST_FRAME,
    ST_CLAMP,
    ST_WAIT_R,
    ST_FRAC,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_ENTRY,
    OP_POSTF,
    OP_LOOPF,
    OP_FRAME,
    OP_CLAMP,
    OP_FRAC
  } dp_op_e;

  typedef enum logic [1:0] {
    DIV_FRAME,
    DIV_LOOP,
    DIV_FRAC
  } div_sel_e;

  typedef struct packed {
    dp_op_e   op;
    logic     div_start;
    div_sel_e div_sel;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic stopped;
    logic enabled;
    logic passed;
    logic per_zero;
    logic wrap;
    logic loop_nz;
    logic den_pos;
    logic div_busy;
  } dp_status_t;

  // Sign-extend a 32-bit time to 34 bits
  function automatic logic signed [33:0] sx34(input logic [31:0] v);
    sx34 = $signed({{2{v[31]}}, v});
  endfunction

endpackage
`default_nettype wire

// ----- rtl/keyframe_animation_stepper.sv -----
// An update that is stopped or disabled, or whose frame is due with a zero
//   frame period, skips the divider; otherwise the frame division, the loop
//   modulo and the back-lerp division run as needed, in turn, all on one
//   shared divider.
// Throughput: one update at a time; the next is taken once the result is in
//   the output register, which may still be waiting for its transfer.
// Reset (rst_ni, async, active low) clears the frame state and loads the
//   register defaults.
`timescale 1ns / 1ps
`default_nettype none
module keyframe_animation_stepper (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_addr_i,
  input  wire logic [30:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [30:0] now_ms_i,
  input  wire logic        stopped_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      prev_frame_o,
  output logic [15:0]      cur_frame_o,
  output logic [16:0]      back_fraction_o
);

  kas_pkg::dp_cmd_t    cmd;
  kas_pkg::dp_status_t status;

  kas_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  kas_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .now_ms_i        (now_ms_i),
    .stopped_i       (stopped_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .prev_frame_o    (prev_frame_o),
    .cur_frame_o     (cur_frame_o),
    .back_fraction_o (back_fraction_o)
  );

endmodule
`default_nettype wire

// ----- rtl/kas_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Restoring shift-subtract divider, one quotient bit per cycle.
// Dividend is left-aligned by the caller; after N steps the quotient
// sits in the low N bits of quotient_o.
module kas_divider (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [kas_pkg::DIVIDEND_W-1:0]  dividend_i,
  input  wire logic [kas_pkg::DIVISOR_W-1:0]   divisor_i,
  input  wire logic [kas_pkg::STEP_W-1:0]      steps_i,
  output logic                                 busy_o,
  output logic [kas_pkg::DIVIDEND_W-1:0]       quotient_o,
  output logic [kas_pkg::DIVISOR_W-1:0]        remainder_o
);

  logic [kas_pkg::DIVIDEND_W-1:0] qd_q, qd_d;
  logic [kas_pkg::DIVISOR_W-1:0]  rem_q, rem_d, dvs_q;
  logic [kas_pkg::STEP_W-1:0]     cnt_q, cnt_d;
  logic                           busy_q, busy_d;
  logic [kas_pkg::DIVISOR_W:0]    trial, diff;
  logic                           ge;

  // one trial subtraction
  always_comb begin
    trial  = {rem_q, qd_q[kas_pkg::DIVIDEND_W-1]};
    diff   = trial - {1'b0, dvs_q};
    ge     = (trial >= {1'b0, dvs_q});
    qd_d   = qd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      qd_d   = dividend_i;
      rem_d  = '0;
      cnt_d  = steps_i;
      busy_d = 1'b1;
    end else if (busy_q) begin
      qd_d  = {qd_q[kas_pkg::DIVIDEND_W-2:0], ge};
      rem_d = ge ? diff[kas_pkg::DIVISOR_W-1:0] : trial[kas_pkg::DIVISOR_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == kas_pkg::STEP_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qd_q  <= qd_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign busy_o      = busy_q;
  assign quotient_o  = qd_q;
  assign remainder_o = rem_q;

endmodule
`default_nettype wire

// ----- rtl/kas_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module kas_datapath (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [2:0]           cfg_addr_i,
  input  wire logic [30:0]          cfg_wdata_i,
  input  wire logic [30:0]          now_ms_i,
  input  wire logic                 stopped_i,
  input  wire kas_pkg::dp_cmd_t     cmd_i,
  output kas_pkg::dp_status_t       status_o,
  output logic [15:0]               prev_frame_o,
  output logic [15:0]               cur_frame_o,
  output logic [16:0]               back_fraction_o
);

  // configuration
  logic [14:0] first_q;
  logic [11:0] count_q, loop_q;
  logic [9:0]  per_q;
  logic        rev_q, flip_q, en_q;
  logic [30:0] start_q;

  // animation state and work registers
  logic [30:0] t_q;
  logic        stop_q, neg_q;
  logic [31:0] next_time_q, prev_time_q, last_time_q;
  logic [31:0] ft_q, ot_q, f_q;
  logic [15:0] hprev_q, hcur_q;
  logic [16:0] hfrac_q;

  // divider hookup
  logic                            div_busy;
  logic [kas_pkg::DIVIDEND_W-1:0]  div_quo, div_dvd;
  logic [kas_pkg::DIVISOR_W-1:0]   div_rem, div_dvs;
  logic [kas_pkg::STEP_W-1:0]      div_steps;

  logic signed [33:0] t34, lead34, den34, num34;
  logic signed [31:0] gap_lim, delta;
  logic [31:0] ft0, x_w, x_abs, fq, fm, ft_c, ot_c;
  logic [12:0] nn;
  logic        passed, wrap, flip_gt, den_pos;
  logic [32:0] num_c;
  logic [15:0] fr;

  // timing and frame arithmetic
  always_comb begin
    t34     = $signed({3'b000, t_q});
    lead34  = t34 + $signed(34'(kas_pkg::LEAD_LIMIT_MS));
    gap_lim = 32'(kas_pkg::PAUSE_GAP_MS);
    delta   = $signed({1'b0, now_ms_i} - last_time_q);
    passed  = (t34 >= kas_pkg::sx34(next_time_q));
    ft0     = (t_q < start_q) ? {1'b0, start_q} : (next_time_q + {22'd0, per_q});
    x_w     = ft0 - {1'b0, start_q};
    x_abs   = x_w[31] ? (32'd0 - x_w) : x_w;
    fq      = neg_q ? (32'd0 - div_quo[31:0]) : div_quo[31:0];
    nn      = flip_q ? {count_q, 1'b0} : {1'b0, count_q};
    wrap    = ($signed(fq) >= $signed({19'd0, nn}));
    fm      = fq - {19'd0, nn};
    flip_gt = flip_q && (count_q != 12'd0) && ($signed(f_q) >= $signed({20'd0, count_q}));
    if (rev_q) begin
      fr = {1'b0, first_q} + {4'd0, count_q} - 16'd1 - f_q[15:0];
    end else if (flip_gt) begin
      fr = {1'b0, first_q} + {4'd0, count_q} - 16'd1 - (f_q[15:0] - {4'd0, count_q});
    end else begin
      fr = {1'b0, first_q} + f_q[15:0];
    end
    // lead limit and previous-time clamp
    ft_c    = (kas_pkg::sx34(ft_q) > lead34) ? {1'b0, t_q} : ft_q;
    ot_c    = (kas_pkg::sx34(ot_q) > t34) ? {1'b0, t_q} : ot_q;
    den34   = kas_pkg::sx34(ft_c) - kas_pkg::sx34(ot_c);
    num34   = t34 - kas_pkg::sx34(ot_c);
    den_pos = !den34[33] && (den34 != 34'sd0);
    if (num34[33]) begin
      num_c = '0;
    end else if (num34 > den34) begin
      num_c = den34[32:0];
    end else begin
      num_c = num34[32:0];
    end
  end

  // divider operand select
  always_comb begin
    unique case (cmd_i.div_sel)
      kas_pkg::DIV_FRAME: begin
        div_dvd   = {x_abs, 17'd0};
        div_dvs   = {23'd0, per_q};
        div_steps = kas_pkg::STEP_W'(32);
      end
      kas_pkg::DIV_LOOP: begin
        div_dvd   = {fm, 17'd0};
        div_dvs   = {21'd0, loop_q};
        div_steps = kas_pkg::STEP_W'(32);
      end
      kas_pkg::DIV_FRAC: begin
        div_dvd   = {num_c, 16'd0};
        div_dvs   = den34[32:0];
        div_steps = kas_pkg::STEP_W'(kas_pkg::DIVIDEND_W);
      end
      default: begin
        div_dvd   = '0;
        div_dvs   = '0;
        div_steps = '0;
      end
    endcase
  end

  kas_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (div_dvd),
    .divisor_i   (div_dvs),
    .steps_i     (div_steps),
    .busy_o      (div_busy),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= '0;
      count_q <= 12'd1;
      loop_q  <= '0;
      per_q   <= 10'd100;
      rev_q   <= 1'b0;
      flip_q  <= 1'b0;
      en_q    <= 1'b1;
      start_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        kas_pkg::CFG_FIRST_FRAME:  first_q <= cfg_wdata_i[14:0];
        kas_pkg::CFG_FRAME_COUNT:  count_q <= cfg_wdata_i[11:0];
        kas_pkg::CFG_LOOP_LENGTH:  loop_q  <= cfg_wdata_i[11:0];
        kas_pkg::CFG_FRAME_PERIOD: per_q   <= cfg_wdata_i[9:0];
        kas_pkg::CFG_REVERSE:      rev_q   <= cfg_wdata_i[0];
        kas_pkg::CFG_FLIP_FLOP:    flip_q  <= cfg_wdata_i[0];
        kas_pkg::CFG_ANIM_ENABLE:  en_q    <= cfg_wdata_i[0];
        kas_pkg::CFG_START_TIME:   start_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // animation state, updated per command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_time_q <= '0;
      prev_time_q <= '0;
      last_time_q <= '0;
      hprev_q     <= '0;
      hcur_q      <= '0;
      hfrac_q     <= '0;
    end else begin
      unique case (cmd_i.op)
        kas_pkg::OP_LOAD: begin
          if (!stopped_i) begin
            if (delta > gap_lim) begin
              prev_time_q <= prev_time_q + delta;
              next_time_q <= next_time_q + delta;
            end
            last_time_q <= {1'b0, now_ms_i};
          end
        end
        kas_pkg::OP_ENTRY: begin
          if (!en_q) begin
            hprev_q <= '0;
            hcur_q  <= '0;
            hfrac_q <= '0;
          end else if (passed) begin
            hprev_q     <= hcur_q;
            prev_time_q <= next_time_q;
          end
        end
        kas_pkg::OP_FRAME: hcur_q <= fr;
        kas_pkg::OP_CLAMP: begin
          next_time_q <= ft_c;
          prev_time_q <= ot_c;
          if (!den_pos) begin
            hfrac_q <= '0;
          end
        end
        kas_pkg::OP_FRAC: hfrac_q <= kas_pkg::FRAC_ONE - div_quo[16:0];
        default: ;
      endcase
    end
  end

  // work registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      kas_pkg::OP_LOAD: begin
        t_q    <= now_ms_i;
        stop_q <= stopped_i;
      end
      kas_pkg::OP_ENTRY: begin
        neg_q <= x_w[31];
        if (passed) begin
          ot_q <= next_time_q;
          ft_q <= ft0;
        end else begin
          ot_q <= prev_time_q;
          ft_q <= next_time_q;
        end
      end
      kas_pkg::OP_POSTF: begin
        if (!wrap) begin
          f_q <= fq;
        end else if (loop_q == 12'd0) begin
          // past the end with no loop: hold the last frame
          f_q  <= {19'd0, nn} - 32'd1;
          ft_q <= {1'b0, t_q};
        end
      end
      kas_pkg::OP_LOOPF: f_q <= div_rem[31:0] + {20'd0, count_q} - {20'd0, loop_q};
      kas_pkg::OP_FRAME: begin
        if (t34 > kas_pkg::sx34(ft_q)) begin
          ft_q <= {1'b0, t_q};
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      prev_frame_o    <= hprev_q;
      cur_frame_o     <= hcur_q;
      back_fraction_o <= hfrac_q;
    end
  end

  always_comb begin
    status_o.stopped  = stop_q;
    status_o.enabled  = en_q;
    status_o.passed   = passed;
    status_o.per_zero = (per_q == 10'd0);
    status_o.wrap     = wrap;
    status_o.loop_nz  = (loop_q != 12'd0);
    status_o.den_pos  = den_pos;
    status_o.div_busy = div_busy;
  end

endmodule
`default_nettype wire

// ----- rtl/kas_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module kas_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  input  wire kas_pkg::dp_status_t  status_i,
  output kas_pkg::dp_cmd_t          cmd_o
);

  kas_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kas_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_d           = state_q;
    cmd_o.op          = kas_pkg::OP_NONE;
    cmd_o.div_start   = 1'b0;
    cmd_o.div_sel     = kas_pkg::DIV_FRAME;
    cmd_o.out_load    = 1'b0;
    in_stall_o        = 1'b1;
    out_valid_d       = out_valid_q && out_stall_i;
    unique case (state_q)
      kas_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.op = kas_pkg::OP_LOAD;
          state_d  = kas_pkg::ST_CHECK;
        end
      end
      kas_pkg::ST_CHECK: begin
        if (status_i.stopped) begin
          state_d = kas_pkg::ST_DONE;
        end else begin
          cmd_o.op = kas_pkg::OP_ENTRY;
          if (!status_i.enabled) begin
            state_d = kas_pkg::ST_DONE;
          end else if (status_i.passed) begin
            if (status_i.per_zero) begin
              state_d = kas_pkg::ST_DONE;
            end else begin
              cmd_o.div_start = 1'b1;
              cmd_o.div_sel   = kas_pkg::DIV_FRAME;
              state_d         = kas_pkg::ST_WAIT_F;
            end
          end else begin
            state_d = kas_pkg::ST_CLAMP;
          end
        end
      end
      kas_pkg::ST_WAIT_F: begin
        if (!status_i.div_busy) begin
          state_d = kas_pkg::ST_POSTF;
        end
      end
      kas_pkg::ST_POSTF: begin
        cmd_o.op = kas_pkg::OP_POSTF;
        if (status_i.wrap && status_i.loop_nz) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = kas_pkg::DIV_LOOP;
          state_d         = kas_pkg::ST_WAIT_L;
        end else begin
          state_d = kas_pkg::ST_FRAME;
        end
      end
      kas_pkg::ST_WAIT_L: begin
        cmd_o.div_sel = kas_pkg::DIV_LOOP;
        if (!status_i.div_busy) begin
          state_d = kas_pkg::ST_LOOPF;
        end
      end
      kas_pkg::ST_LOOPF: begin
        cmd_o.op = kas_pkg::OP_LOOPF;
        state_d  = kas_pkg::ST_FRAME;
      end
      kas_pkg::ST_FRAME: begin
        cmd_o.op = kas_pkg::OP_FRAME;
        state_d  = kas_pkg::ST_CLAMP;
      end
      kas_pkg::ST_CLAMP: begin
        cmd_o.op      = kas_pkg::OP_CLAMP;
        cmd_o.div_sel = kas_pkg::DIV_FRAC;
        if (status_i.den_pos) begin
          cmd_o.div_start = 1'b1;
          state_d         = kas_pkg::ST_WAIT_R;
        end else begin
          state_d = kas_pkg::ST_DONE;
        end
      end
      kas_pkg::ST_WAIT_R: begin
        if (!status_i.div_busy) begin
          state_d = kas_pkg::ST_FRAC;
        end
      end
      kas_pkg::ST_FRAC: begin
        cmd_o.op = kas_pkg::OP_FRAC;
        state_d  = kas_pkg::ST_DONE;
      end
      kas_pkg::ST_DONE: begin
        // hand the result to the output register once it is free
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = kas_pkg::ST_IDLE;
        end
      end
      default: state_d = kas_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ----- rtl/kas_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module kas_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [15:0] prev_frame_o,
  input wire logic [15:0] cur_frame_o,
  input wire logic [16:0] back_fraction_o
);

  // a result waiting for transfer stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(prev_frame_o) && $stable(cur_frame_o)
      && $stable(back_fraction_o))
    else $error("stalled result changed");

  // one update in flight: input is stalled right after a transfer
  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second update taken while busy");

  // a result never appears in the cycle after its update is taken
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result appeared too early");

endmodule

bind keyframe_animation_stepper kas_checker u_kas_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .prev_frame_o    (prev_frame_o),
  .cur_frame_o     (cur_frame_o),
  .back_fraction_o (back_fraction_o)
);
`default_nettype wire
